/* hw/rtl/spectral_cube_block_average_unit_macros.svh */
// assertion macros shared by the block average unit
`ifndef SPECTRAL_CUBE_BLOCK_AVERAGE_UNIT_MACROS_SVH
`define SPECTRAL_CUBE_BLOCK_AVERAGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define SCBA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("scba assertion failed: invariant");

// same-cycle implication
`define SCBA_ASSERT_IMPLIES(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("scba assertion failed: implication");

// next-cycle implication
`define SCBA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("scba assertion failed: next-cycle implication");

`else

`define SCBA_ASSERT_ALWAYS(label, prop)
`define SCBA_ASSERT_IMPLIES(label, cond, prop)
`define SCBA_ASSERT_NEXT(label, cond, prop)

`endif

`endif

/* hw/rtl/scba_pkg.sv */
// shared constants and types of the block average unit
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

    // default sizing of the accumulator store and position counters
    localparam int SCBA_MAX_BINS_ACROSS = 64;
    localparam int SCBA_MAX_CHANNELS    = 256;
    localparam int SCBA_MAX_BIN_LOG2    = 6;

    // accumulator and mean shift widths
    localparam int ACC_W   = 44;
    localparam int SHIFT_W = 5;

    // result queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    // configuration register map
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_BINS_ACROSS   = 2'd1;
    localparam logic [1:0] REG_BIN_LOG2      = 2'd2;

    // per-sample position info handed to the accumulator pipeline
    typedef struct packed {
        logic               start;
        logic               last;
        logic [7:0]         chan;
        logic [5:0]         bcol;
        logic [9:0]         brow;
        logic [SHIFT_W-1:0] shift;
    } pos_t;

    // one finished bin mean
    typedef struct packed {
        logic signed [31:0] mean;
        logic [7:0]         chan;
        logic [5:0]         bcol;
        logic [9:0]         brow;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/spectral_cube_block_average_unit.sv */
// Spatial block average of a streamed spectral cube. Samples come in raster order
// (channel fastest, then pixel column, then pixel row) and one sample is taken per
// clock while ready: each sample does one read-modify-write of the accumulator
// memory, read in the accept cycle and added and written back in the next, with
// forwarding when two consecutive samples hit the same entry. A bin mean for
// a channel leaves through stage two and a four-entry result queue; s_ready drops
// only while that queue and the results still in the pipeline would fill it. The
// accumulator memory needs no clearing pass after reset, since the first sample of
// every bin loads its entry. Write the registers only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module spectral_cube_block_average_unit
    import scba_pkg::*;
#(
    parameter int MAX_BINS_ACROSS = SCBA_MAX_BINS_ACROSS,
    parameter int MAX_CHANNELS    = SCBA_MAX_CHANNELS,
    parameter int MAX_BIN_LOG2    = SCBA_MAX_BIN_LOG2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [31:0]    s_sample,
    input  wire logic                  s_first,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_mean_value,
    output logic      [7:0]            m_channel,
    output logic      [5:0]            m_bin_col,
    output logic      [9:0]            m_bin_row
);

    localparam int DEPTH = MAX_BINS_ACROSS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [8:0] channel_count_reg;
    logic [6:0] bins_across_reg;
    logic [2:0] bin_log2_reg;
    logic       cfg_write;

    logic               accept;
    logic [AW-1:0]      addr;
    pos_t               pos;
    logic               res_valid;
    res_t               res;
    res_t               out_data;
    logic [1:0]         pend_cnt;
    logic [OUTQ_CW-1:0] q_count;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= 9'd1;
            bins_across_reg   <= 7'd1;
            bin_log2_reg      <= 3'd0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[8:0];
                REG_BINS_ACROSS:   bins_across_reg   <= pwdata[6:0];
                REG_BIN_LOG2:      bin_log2_reg      <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_CHANNEL_COUNT: prdata = {23'd0, channel_count_reg};
            REG_BINS_ACROSS:   prdata = {25'd0, bins_across_reg};
            REG_BIN_LOG2:      prdata = {29'd0, bin_log2_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // take a sample while the queue can hold every result in flight
    assign s_ready = (4'(q_count) + 4'(pend_cnt)) < 4'(OUTQ_DEPTH);
    assign accept  = s_valid && s_ready;

    scba_pos #(
        .MAX_BINS_ACROSS (MAX_BINS_ACROSS),
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_BIN_LOG2    (MAX_BIN_LOG2),
        .AW              (AW)
    ) u_pos (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .first         (s_first),
        .channel_count (channel_count_reg),
        .bins_across   (bins_across_reg),
        .bin_log2      (bin_log2_reg),
        .addr          (addr),
        .pos           (pos)
    );

    scba_acc #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .addr_in   (addr),
        .sample_in (s_sample),
        .pos_in    (pos),
        .res_valid (res_valid),
        .res       (res),
        .pend_cnt  (pend_cnt)
    );

    scba_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (q_count)
    );

    // result channel payload
    assign m_mean_value = out_data.mean;
    assign m_channel    = out_data.chan;
    assign m_bin_col    = out_data.bcol;
    assign m_bin_row    = out_data.brow;

endmodule

`default_nettype wire

/* hw/rtl/scba_pos.sv */
// raster position counters and accumulator address generation
`timescale 1ns / 1ps
`default_nettype none

module scba_pos
    import scba_pkg::*;
#(
    parameter int MAX_BINS_ACROSS = SCBA_MAX_BINS_ACROSS,
    parameter int MAX_CHANNELS    = SCBA_MAX_CHANNELS,
    parameter int MAX_BIN_LOG2    = SCBA_MAX_BIN_LOG2,
    parameter int AW              = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire logic          first,
    input  wire logic [8:0]    channel_count,
    input  wire logic [6:0]    bins_across,
    input  wire logic [2:0]    bin_log2,
    output logic      [AW-1:0] addr,
    output pos_t               pos
);

    localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW  = $clog2(MAX_CHANNELS + 1);
    localparam int BAW  = $clog2(MAX_BINS_ACROSS + 1);
    localparam int BCW  = (MAX_BINS_ACROSS > 1) ? $clog2(MAX_BINS_ACROSS) : 1;
    localparam int RW   = (MAX_BIN_LOG2 > 0) ? MAX_BIN_LOG2 : 1;
    localparam int SW   = MAX_BIN_LOG2 + 1;
    localparam int COLW = BCW + MAX_BIN_LOG2;
    localparam int WW   = BAW + MAX_BIN_LOG2;
    localparam int LGW  = (MAX_BIN_LOG2 > 0) ? $clog2(MAX_BIN_LOG2 + 1) : 1;

    logic [CW-1:0]   chan_reg, chan_next, chan_cur;
    logic [COLW-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0]   row_reg, row_next, row_cur;
    logic [9:0]      brow_reg, brow_next, brow_cur;

    logic [CCW-1:0]  cc_eff;
    logic [BAW-1:0]  ba_eff;
    logic [LGW-1:0]  lg_eff;
    logic [WW-1:0]   width_eff;
    logic [SW-1:0]   side;
    logic [COLW-1:0] cin;
    logic [BCW-1:0]  bcol;
    logic [CW:0]     chan_inc;
    logic [COLW:0]   col_inc;
    logic [RW:0]     row_inc;
    logic            wrap_ch, wrap_col, wrap_row;

    // clamp registers to their meaningful ranges
    always_comb begin
        if (channel_count == 9'd0) begin
            cc_eff = CCW'(1);
        end else if (32'(channel_count) > MAX_CHANNELS) begin
            cc_eff = CCW'(MAX_CHANNELS);
        end else begin
            cc_eff = CCW'(channel_count);
        end
        if (bins_across == 7'd0) begin
            ba_eff = BAW'(1);
        end else if (32'(bins_across) > MAX_BINS_ACROSS) begin
            ba_eff = BAW'(MAX_BINS_ACROSS);
        end else begin
            ba_eff = BAW'(bins_across);
        end
        if (32'(bin_log2) > MAX_BIN_LOG2) begin
            lg_eff = LGW'(MAX_BIN_LOG2);
        end else begin
            lg_eff = LGW'(bin_log2);
        end
    end

    assign width_eff = WW'(ba_eff) << lg_eff;
    assign side      = SW'(1) << lg_eff;

    // position of this sample, restarted by first and wrapped past the registers
    always_comb begin
        chan_cur = first ? '0 : chan_reg;
        col_cur  = first ? '0 : col_reg;
        row_cur  = first ? '0 : row_reg;
        brow_cur = first ? '0 : brow_reg;
        if (chan_cur >= cc_eff) begin
            chan_cur = '0;
        end
        if (col_cur >= width_eff) begin
            col_cur = '0;
        end
        if (row_cur >= side) begin
            row_cur = '0;
        end
    end

    // bin column, column inside the bin, store address
    assign bcol = BCW'(col_cur >> lg_eff);
    assign cin  = col_cur & COLW'(side - SW'(1));
    assign addr = AW'(bcol * MAX_CHANNELS + chan_cur);

    assign pos.start = (cin == '0) && (row_cur == '0);
    assign pos.last  = (cin == COLW'(side - SW'(1))) && (row_cur == RW'(side - SW'(1)));
    assign pos.chan  = 8'(chan_cur);
    assign pos.bcol  = 6'(bcol);
    assign pos.brow  = brow_cur;
    assign pos.shift = SHIFT_W'({lg_eff, 1'b0});

    // advance channel, then column, then row inside the bin, then bin row
    always_comb begin
        chan_inc  = (CW + 1)'(chan_cur) + (CW + 1)'(1);
        col_inc   = (COLW + 1)'(col_cur) + (COLW + 1)'(1);
        row_inc   = (RW + 1)'(row_cur) + (RW + 1)'(1);
        wrap_ch   = chan_inc >= cc_eff;
        wrap_col  = wrap_ch && (col_inc >= width_eff);
        wrap_row  = wrap_col && (row_inc >= side);
        chan_next = wrap_ch ? '0 : CW'(chan_inc);
        col_next  = wrap_ch ? (wrap_col ? '0 : COLW'(col_inc)) : col_cur;
        row_next  = wrap_col ? (wrap_row ? '0 : RW'(row_inc)) : row_cur;
        brow_next = wrap_row ? brow_cur + 10'd1 : brow_cur;
    end

    // counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            brow_reg <= '0;
        end else if (accept) begin
            chan_reg <= chan_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            brow_reg <= brow_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/scba_acc.sv */
// accumulator store with read-modify-write pipeline and mean shift
`timescale 1ns / 1ps
`default_nettype none

`include "spectral_cube_block_average_unit_macros.svh"

module scba_acc
    import scba_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic      [AW-1:0] addr_in,
    input  wire logic signed [31:0] sample_in,
    input  wire pos_t               pos_in,
    output logic                    res_valid,
    output res_t                    res,
    output logic           [1:0]    pend_cnt
);

    logic [ACC_W-1:0] mem [DEPTH];
    logic [ACC_W-1:0] rdata_reg;

    logic             v1_reg, fwd1_reg, fwd1_next;
    logic [AW-1:0]    addr1_reg;
    logic [ACC_W-1:0] smp1_reg;
    pos_t             pos1_reg;
    logic [ACC_W-1:0] wacc_reg;

    logic             v2_reg;
    logic [ACC_W-1:0] acc2_reg;
    pos_t             pos2_reg;

    logic [ACC_W-1:0]        base;
    logic [ACC_W-1:0]        acc_sum;
    logic signed [ACC_W-1:0] shifted;

    // accumulator memory, read on accept, written from stage one
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            mem[addr1_reg] <= acc_sum;
        end
        if (accept) begin
            rdata_reg <= mem[addr_in];
        end
    end

    // entry being written this cycle is the one just read: take it from wacc_reg
    assign fwd1_next = v1_reg && (addr1_reg == addr_in);

    // stage one: add to the stored partial sum or load on the first sample of a bin
    assign base    = fwd1_reg ? wacc_reg : rdata_reg;
    assign acc_sum = pos1_reg.start ? smp1_reg : base + smp1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            fwd1_reg <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (accept) begin
                fwd1_reg <= fwd1_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr1_reg <= addr_in;
            smp1_reg  <= {{(ACC_W - 32){sample_in[31]}}, sample_in};
            pos1_reg  <= pos_in;
        end
        if (v1_reg) begin
            wacc_reg <= acc_sum;
            acc2_reg <= acc_sum;
            pos2_reg <= pos1_reg;
        end
    end

    // stage two: floored mean by arithmetic shift
    assign shifted   = $signed(acc2_reg) >>> pos2_reg.shift;
    assign res_valid = v2_reg && pos2_reg.last;
    assign res.mean  = shifted[31:0];
    assign res.chan  = pos2_reg.chan;
    assign res.bcol  = pos2_reg.bcol;
    assign res.brow  = pos2_reg.brow;

    // results still in flight toward the queue
    assign pend_cnt = {1'b0, v1_reg && pos1_reg.last} + {1'b0, v2_reg && pos2_reg.last};

    // forwarding only follows a write of the same entry in the previous cycle
    `SCBA_ASSERT_IMPLIES(a_fwd_src, v1_reg && fwd1_reg, $past(v1_reg) && ($past(addr1_reg) == addr1_reg))
    // a one-pixel bin both opens and closes with the same sample
    `SCBA_ASSERT_IMPLIES(a_unit_bin, v2_reg && (pos2_reg.shift == '0), pos2_reg.start && pos2_reg.last)
    // stage one always moves on to stage two
    `SCBA_ASSERT_NEXT(a_stage_two, v1_reg, v2_reg)

endmodule

`default_nettype wire

/* hw/rtl/scba_outq.sv */
// small result queue between the pipeline and the result channel
`timescale 1ns / 1ps
`default_nettype none

`include "spectral_cube_block_average_unit_macros.svh"

module scba_outq
    import scba_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire res_t               push_data,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output res_t                    out_data,
    output logic      [OUTQ_CW-1:0] count
);

    res_t               entry_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0] count_reg, count_next;
    logic               pop;

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + OUTQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SCBA_ASSERT_ALWAYS(a_cnt_bound, count_reg <= OUTQ_CW'(OUTQ_DEPTH))
    `SCBA_ASSERT_IMPLIES(a_no_overflow, push, (count_reg < OUTQ_CW'(OUTQ_DEPTH)) || pop)
    `SCBA_ASSERT_NEXT(a_cnt_up, push && !pop, count_reg == $past(count_reg) + OUTQ_CW'(1))

endmodule

`default_nettype wire
